// ----- design/dip_pkg.sv -----
// shared types and constants for the decimal integer parser
// character codes, parse modes, scan phases and result status codes
// no dependencies
package dip_pkg;

   localparam int unsigned MAX_FIELD_CHARS_DEF = 255;

   localparam int unsigned CHAR_W   = 8;
   localparam int unsigned VALUE_W  = 64;
   localparam int unsigned COUNT_W  = 8;
   localparam int unsigned MODE_W   = 2;
   localparam int unsigned STATUS_W = 2;
   // value, status and count packed, padded to whole bytes
   localparam int unsigned RSP_W    = 80;
   // product of accumulator and ten plus a digit
   localparam int unsigned WIDE_W   = VALUE_W + 4;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   localparam logic [MODE_W-1:0] MODE_S32 = 2'd0;
   localparam logic [MODE_W-1:0] MODE_U32 = 2'd1;
   localparam logic [MODE_W-1:0] MODE_U64 = 2'd2;

   localparam logic [WIDE_W-1:0] LIM_S32_POS = 68'h0_0000_0000_7FFF_FFFF;
   localparam logic [WIDE_W-1:0] LIM_S32_NEG = 68'h0_0000_0000_8000_0000;
   localparam logic [WIDE_W-1:0] LIM_U32     = 68'h0_0000_0000_FFFF_FFFF;
   localparam logic [WIDE_W-1:0] LIM_U64     = 68'h0_FFFF_FFFF_FFFF_FFFF;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

   typedef enum logic [1:0] {
      PH_PLUS   = 2'd0,
      PH_MINUS  = 2'd1,
      PH_DIGITS = 2'd2,
      PH_STOP   = 2'd3
   } phase_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_NODIG = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

endpackage

// ----- design/decimal_integer_parser.sv -----
// decimal string to integer parser, one character beat per cycle unless stalled
// depends on dip_pkg for character codes, modes, phases and status codes
//
// The block takes one text field as a stream of character beats on req_, with
// req_tlast on the field's last character, and returns one result beat on rsp_
// per field: the value, a status (0 success, 1 no digits, 2 out of range) and
// the number of sign and digit characters consumed (saturating at 255). An
// optional '+' and, in signed mode, an optional '-' lead the digits; the first
// non-digit stops the scan and the rest of the field is ignored, as is every
// character past MAX_FIELD_CHARS. csr_data selects the mode: 0 signed 32-bit
// saturating to the int limits, 1 unsigned 32-bit and 2 (or 3) unsigned 64-bit,
// both of which wrap and flag overflow. Write the mode only between fields.
// Throughput is one character per cycle with no gaps between fields, but for
// the stall below. The cycle time is set by the single scan step: accumulator
// times ten plus digit (shift-add), a 68-bit range compare and the state
// update. rsp_ holds its beat while stalled; characters keep flowing
// meanwhile until the next field's last character waits in the input register,
// which drops req_tready.

module decimal_integer_parser #(
   parameter int unsigned MAX_FIELD_CHARS = dip_pkg::MAX_FIELD_CHARS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // character beats
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [dip_pkg::CHAR_W-1:0]  req_tdata,   // [7:0] char_code
   input  logic                        req_tlast,   // field_end
   // result beats
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [dip_pkg::RSP_W-1:0]   rsp_tdata,   // [63:0] parsed_value,
                                                    // [65:64] parse_status,
                                                    // [73:66] chars_consumed,
                                                    // [79:74] zero
   // mode register write
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [dip_pkg::MODE_W-1:0]  csr_data     // parse_mode
);
   import dip_pkg::*;

   localparam int unsigned POS_W = $clog2(MAX_FIELD_CHARS + 1);
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FIELD_CHARS);
   localparam int unsigned PAD_W = RSP_W - VALUE_W - STATUS_W - COUNT_W;

   // mode register
   logic [MODE_W-1:0] mode_ff;

   // input register
   logic              in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0] in_char_ff;
   logic              in_last_ff;

   // per-field scan state
   phase_type          phase_ff, phase_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic               neg_ff, neg_in;
   status_type         status_ff, status_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [POS_W-1:0]   pos_ff, pos_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] res_acc_ff;
   logic               res_neg_ff;
   logic [MODE_W-1:0]  res_mode_ff;
   status_type         res_status_ff;
   logic [COUNT_W-1:0] res_count_ff;

   // step control
   logic               advance;
   logic               field_done;
   logic               is_signed;
   logic               is_digit, is_plus, is_minus;
   logic [CHAR_W-1:0]  char_off;
   logic               consume, take;
   logic [WIDE_W-1:0]  wide_acc, prod, lim;
   logic               over;

   // output formatting
   logic [31:0]        mag32, val32;
   logic [VALUE_W-1:0] fmt_value;

   assign csr_ready = 1'b1;

   // an item leaves the input register when it yields no result or the
   // result slot is free or being drained this cycle
   assign advance    = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign field_done = advance && in_last_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (field_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // character classification
   assign is_signed = (mode_ff == MODE_S32);
   assign is_digit  = (in_char_ff >= CHAR_ZERO) && (in_char_ff <= CHAR_NINE);
   assign is_plus   = (in_char_ff == CHAR_PLUS);
   assign is_minus  = (in_char_ff == CHAR_MINUS);
   assign char_off  = in_char_ff - CHAR_ZERO;

   // acc * 10 + digit, wide enough that nothing is lost
   assign wide_acc = {4'b0, acc_ff};
   assign prod     = (wide_acc << 3) + (wide_acc << 1) + WIDE_W'(char_off[3:0]);

   always_comb begin
      case (mode_ff)
         MODE_S32: lim = neg_ff ? LIM_S32_NEG : LIM_S32_POS;
         MODE_U32: lim = LIM_U32;
         default:  lim = LIM_U64;
      endcase
   end

   assign over = (prod > lim);

   // scan phase sequencing
   always_comb begin
      phase_in = phase_ff;
      neg_in   = neg_ff;
      pos_in   = pos_ff;
      consume  = 1'b0;
      take     = 1'b0;
      if (pos_ff < POS_MAX) begin
         pos_in = pos_ff + 1'b1;
         case (phase_ff)
            PH_PLUS: begin
               if (is_plus) begin
                  phase_in = is_signed ? PH_MINUS : PH_DIGITS;
                  consume  = 1'b1;
               end else if (is_signed && is_minus) begin
                  neg_in   = 1'b1;
                  phase_in = PH_DIGITS;
                  consume  = 1'b1;
               end else if (is_digit) begin
                  take     = 1'b1;
                  consume  = 1'b1;
                  phase_in = PH_DIGITS;
               end else begin
                  phase_in = PH_STOP;
               end
            end
            PH_MINUS: begin
               if (is_signed && is_minus) begin
                  neg_in   = 1'b1;
                  phase_in = PH_DIGITS;
                  consume  = 1'b1;
               end else if (is_digit) begin
                  take     = 1'b1;
                  consume  = 1'b1;
                  phase_in = PH_DIGITS;
               end else begin
                  phase_in = PH_STOP;
               end
            end
            PH_DIGITS: begin
               if (is_digit) begin
                  take    = 1'b1;
                  consume = 1'b1;
               end else begin
                  phase_in = PH_STOP;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // accumulate one digit; signed mode saturates, unsigned modes wrap
   always_comb begin
      acc_in    = acc_ff;
      status_in = status_ff;
      count_in  = count_ff;
      if (consume && (count_ff != COUNT_MAX)) begin
         count_in = count_ff + 1'b1;
      end
      if (take) begin
         if (is_signed) begin
            if (status_ff != ST_RANGE) begin
               if (over) begin
                  acc_in    = lim[VALUE_W-1:0];
                  status_in = ST_RANGE;
               end else begin
                  acc_in    = prod[VALUE_W-1:0];
                  status_in = ST_OK;
               end
            end
         end else begin
            acc_in = prod[VALUE_W-1:0] & lim[VALUE_W-1:0];
            if (over) begin
               status_in = ST_RANGE;
            end else if (status_ff != ST_RANGE) begin
               status_in = ST_OK;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_S32;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_PLUS;
         acc_ff       <= '0;
         neg_ff       <= 1'b0;
         status_ff    <= ST_NODIG;
         count_ff     <= '0;
         pos_ff       <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_data;
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (field_done) begin
            // back to the start state for the next field
            phase_ff  <= PH_PLUS;
            acc_ff    <= '0;
            neg_ff    <= 1'b0;
            status_ff <= ST_NODIG;
            count_ff  <= '0;
            pos_ff    <= '0;
         end else if (advance) begin
            phase_ff  <= phase_in;
            acc_ff    <= acc_in;
            neg_ff    <= neg_in;
            status_ff <= status_in;
            count_ff  <= count_in;
            pos_ff    <= pos_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (field_done) begin
         res_acc_ff    <= acc_in;
         res_neg_ff    <= neg_in;
         res_mode_ff   <= mode_ff;
         res_status_ff <= status_in;
         res_count_ff  <= count_in;
      end
   end

   // result formatting from the result register
   assign mag32 = res_acc_ff[31:0];
   assign val32 = res_neg_ff ? (32'd0 - mag32) : mag32;

   always_comb begin
      if (res_status_ff == ST_NODIG) begin
         fmt_value = '0;
      end else begin
         case (res_mode_ff)
            MODE_S32: fmt_value = {{32{val32[31]}}, val32};
            MODE_U32: fmt_value = {32'd0, mag32};
            default:  fmt_value = res_acc_ff;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, res_count_ff, res_status_ff, fmt_value};

   // a field still waiting for its first character has a clean state
   a_start_clean: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PLUS) |-> (acc_ff == '0) && (count_ff == '0)
                                && (status_ff == ST_NODIG))
      else $error("scan state not clean at field start");

   // success or overflow status only after a digit was taken
   a_ok_phase: assert property (@(posedge clock) disable iff (reset)
      (status_ff != ST_NODIG) |-> (phase_ff == PH_DIGITS) || (phase_ff == PH_STOP))
      else $error("digit status outside digit phase");

   // a result with digits has counted at least one character
   a_res_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (res_status_ff != ST_NODIG)) |-> (res_count_ff != '0))
      else $error("result with digits but zero count");

   // a finished field always shows a result next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      field_done |=> rsp_valid_ff)
      else $error("field end without result");

   // character position never passes the field limit
   a_pos_limit: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_MAX)
      else $error("field position beyond limit");

endmodule

// ----- tb/dip_result_monitor.sv -----
`timescale 1ns / 1ps
// result monitor for the decimal integer parser: keeps its own scan state per field
// and compares every result beat with the oldest predicted one
// depends on dip_pkg for character codes, parse modes, phases and status codes
module dip_result_monitor #(
   parameter int unsigned MAX_FIELD_CHARS = dip_pkg::MAX_FIELD_CHARS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [dip_pkg::CHAR_W-1:0] req_tdata,   // [7:0] char_code
   input  logic                       req_tlast,   // field_end
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [dip_pkg::RSP_W-1:0]  rsp_tdata,   // [63:0] value, [65:64] status,
                                                   // [73:66] consumed
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [dip_pkg::MODE_W-1:0] csr_data,    // parse_mode
   output int unsigned                fail_count,
   output int unsigned                fields_pending
);
   import dip_pkg::*;

   localparam logic [VALUE_W-1:0] SAT_POS = 64'h0000_0000_7FFF_FFFF;
   localparam logic [VALUE_W-1:0] SAT_NEG = 64'h0000_0000_8000_0000;
   localparam logic [VALUE_W-1:0] WRAP_32 = 64'h0000_0000_FFFF_FFFF;
   localparam logic [VALUE_W-1:0] WRAP_64 = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      status_type         status;
      logic [COUNT_W-1:0] consumed;
   } field_result_type;

   field_result_type    field_results[$];
   field_result_type    oldest;
   logic [MODE_W-1:0]   cur_mode;
   phase_type           scan_ph;
   logic [VALUE_W-1:0]  accum;
   logic                is_negative;
   status_type          run_status;
   logic [COUNT_W-1:0]  consumed;
   int unsigned         char_pos;
   int unsigned         mismatches;
   logic [VALUE_W-1:0]  final_val;
   logic [31:0]         low_word;

   task clear_field();
      scan_ph     = PH_PLUS;
      accum       = '0;
      is_negative = 1'b0;
      run_status  = ST_NODIG;
      consumed    = '0;
      char_pos    = 0;
   endtask

   task count_char();
      if (consumed != COUNT_MAX)
         consumed = consumed + 1'b1;
   endtask

   task note_mismatch(input string what, input logic [VALUE_W-1:0] want,
                      input logic [VALUE_W-1:0] got);
      if (mismatches < 10)
         $display("mismatch %s: expected %h actual %h at %0t", what, want, got, $realtime);
      mismatches++;
   endtask

   // one character under the mode in force at its beat
   task scan_char(input logic [CHAR_W-1:0] c);
      logic [VALUE_W-1:0] d;
      logic [VALUE_W-1:0] lim;
      bit                 taken;
      taken = 1'b0;
      if (char_pos < MAX_FIELD_CHARS) begin
         char_pos++;
         if (scan_ph == PH_PLUS) begin
            if (c == CHAR_PLUS) begin
               scan_ph = (cur_mode == MODE_S32) ? PH_MINUS : PH_DIGITS;
               count_char();
               taken = 1'b1;
            end else begin
               scan_ph = PH_MINUS;
            end
         end
         if (!taken && scan_ph == PH_MINUS) begin
            if (cur_mode == MODE_S32 && c == CHAR_MINUS) begin
               is_negative = 1'b1;
               scan_ph = PH_DIGITS;
               count_char();
               taken = 1'b1;
            end else begin
               scan_ph = PH_DIGITS;
            end
         end
         if (!taken && scan_ph == PH_DIGITS) begin
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
               d = {56'd0, c - CHAR_ZERO};
               if (cur_mode == MODE_S32) begin
                  // saturating magnitude, sticks once out of range
                  if (run_status != ST_RANGE) begin
                     lim = is_negative ? SAT_NEG : SAT_POS;
                     if (accum > (lim - d) / 10) begin
                        accum = lim;
                        run_status = ST_RANGE;
                     end else begin
                        accum = accum * 10 + d;
                        run_status = ST_OK;
                     end
                  end
               end else begin
                  // wrapping value, overflow flag is sticky
                  lim = (cur_mode == MODE_U32) ? WRAP_32 : WRAP_64;
                  if (accum > (lim - d) / 10)
                     run_status = ST_RANGE;
                  else if (run_status != ST_RANGE)
                     run_status = ST_OK;
                  accum = (accum * 10 + d) & lim;
               end
               count_char();
            end else begin
               scan_ph = PH_STOP;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cur_mode = MODE_S32;
         clear_field();
         field_results.delete();
         mismatches = 0;
      end else begin
         // results are compared before this edge's character is scanned
         if (rsp_tvalid && rsp_tready) begin
            if (field_results.size() == 0) begin
               note_mismatch("unexpected result beat", '0, rsp_tdata[63:0]);
            end else begin
               oldest = field_results.pop_front();
               if (rsp_tdata[63:0] !== oldest.value)
                  note_mismatch("parsed_value", oldest.value, rsp_tdata[63:0]);
               if (rsp_tdata[65:64] !== oldest.status)
                  note_mismatch("parse_status", {62'd0, oldest.status},
                                {62'd0, rsp_tdata[65:64]});
               if (rsp_tdata[73:66] !== oldest.consumed)
                  note_mismatch("chars_consumed", {56'd0, oldest.consumed},
                                {56'd0, rsp_tdata[73:66]});
            end
         end
         if (req_tvalid && req_tready) begin
            scan_char(req_tdata);
            if (req_tlast) begin
               if (run_status == ST_NODIG) begin
                  final_val = '0;
               end else if (cur_mode == MODE_S32) begin
                  low_word = accum[31:0];
                  if (is_negative)
                     low_word = 32'd0 - low_word;
                  final_val = {{32{low_word[31]}}, low_word};
               end else if (cur_mode == MODE_U32) begin
                  final_val = {32'd0, accum[31:0]};
               end else begin
                  final_val = accum;
               end
               field_results.push_back('{value: final_val, status: run_status,
                                         consumed: consumed});
               clear_field();
            end
         end
         if (csr_valid && csr_ready)
            cur_mode = csr_data;
      end
      fail_count     <= mismatches;
      fields_pending <= field_results.size();
   end

endmodule

// ----- tb/tb_decimal_integer_parser.sv -----
`timescale 1ns / 1ps
// top of the decimal integer parser testbench: clock, reset, field stimulus,
// receiver stalls and the verdict; depends on dip_pkg, the block and dip_result_monitor
module tb_decimal_integer_parser;
   import dip_pkg::*;

   // mode code 3 is unused and behaves as unsigned 64-bit
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
   localparam int unsigned CYCLE_LIMIT   = 2000000;
   localparam int unsigned SETTLE_CYCLES = 8;   // a result is registered after the input register
   localparam int unsigned PHASE_ITEMS   = 110;
   localparam int unsigned NUM_PHASES    = 7;

   typedef logic [CHAR_W-1:0] char_q_type[$];

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic [CHAR_W-1:0]   req_tdata  = '0;
   logic                req_tlast  = 1'b0;
   logic                rsp_tready = 1'b0;
   logic                csr_valid  = 1'b0;
   logic [MODE_W-1:0]   csr_data   = '0;
   wire                 req_tready;
   wire                 rsp_tvalid;
   wire [RSP_W-1:0]     rsp_tdata;
   wire                 csr_ready;
   int unsigned         fail_count;
   int unsigned         fields_pending;

   int unsigned         cycle_count = 0;
   int unsigned         items_sent  = 0;
   int unsigned         burst_left  = 0;
   int unsigned         stall_style = 0;
   int unsigned         stall_left  = 0;
   logic [15:0]         stall_mask  = '1;

   // decimal texts at and one past the 32- and 64-bit limits
   string limit_text[6] = '{"2147483647", "2147483648", "4294967295",
                            "4294967296", "18446744073709551615",
                            "18446744073709551616"};

   // mode sequence of the random phases, every code and both extremes
   logic [MODE_W-1:0] phase_modes[NUM_PHASES] = '{MODE_U32, MODE_U64, MODE_SPARE,
                                                  MODE_S32, MODE_U64, MODE_U32,
                                                  MODE_S32};

   always #5 clock = ~clock;

   decimal_integer_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [7:0] char_code
      .req_tlast  (req_tlast),    // field_end
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [63:0] value, [65:64] status, [73:66] consumed
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)      // parse_mode
   );

   dip_result_monitor #(
      .MAX_FIELD_CHARS (MAX_FIELD_CHARS_DEF)
   ) monitor (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .fail_count     (fail_count),
      .fields_pending (fields_pending)
   );

   // watchdog on the whole run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL decimal_integer_parser");
         $finish;
      end
   end

   // receiver: switches at random between styles of stalling,
   // always ready, coin flip, mostly stalled, or a rotating 16-bit mask
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_style = $urandom_range(0, 3);
         stall_left  = $urandom_range(20, 150);
         stall_mask  = 16'($urandom);
      end else begin
         stall_left--;
      end
      case (stall_style)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: begin
            rsp_tready <= stall_mask[0];
            stall_mask = {stall_mask[0], stall_mask[15:1]};
         end
      endcase
   end

   function automatic logic [CHAR_W-1:0] rand_digit();
      return CHAR_ZERO + CHAR_W'($urandom_range(0, 9));
   endfunction

   function automatic logic [CHAR_W-1:0] rand_byte();
      return CHAR_W'($urandom_range(0, 255));
   endfunction

   // one character beat; valid stays high across a burst, gaps come between bursts
   task automatic send_beat(input logic [CHAR_W-1:0] c, input logic last_char);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 16) : $urandom_range(0, 3);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         // long bursts give stretches with no idling at all
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last_char;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      items_sent++;
   endtask

   task automatic send_field(input char_q_type f);
      foreach (f[i])
         send_beat(f[i], i == f.size() - 1);
   endtask

   task automatic push_text(inout char_q_type f, input string s);
      for (int i = 0; i < s.len(); i++)
         f.push_back(s[i]);
   endtask

   task automatic send_text(input string s);
      char_q_type f;
      f = {};
      push_text(f, s);
      send_field(f);
   endtask

   // drain: all results back, then a settling wait for anything in flight
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (fields_pending == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic [MODE_W-1:0] m);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // random field: mostly well-formed numbers, the rest odd signs and noise
   task automatic build_field(input bit overlong, output char_q_type f);
      int unsigned     kind;
      logic [63:0]     rnd_val;
      f = {};
      if (overlong) begin
         // past the per-field character limit, count saturates at 255
         repeat ($urandom_range(256, 280)) f.push_back(rand_digit());
      end else begin
         kind = $urandom_range(0, 99);
         if (kind < 55) begin
            case ($urandom_range(0, 3))
               1: f.push_back(CHAR_PLUS);
               2: f.push_back(CHAR_MINUS);
               3: begin
                  f.push_back(CHAR_PLUS);
                  f.push_back(CHAR_MINUS);
               end
               default: ;
            endcase
            case ($urandom_range(0, 3))
               0: begin
                  // near a limit: tweak the last digit, sometimes one digit more
                  push_text(f, limit_text[$urandom_range(0, 5)]);
                  if ($urandom_range(0, 1))
                     f[f.size() - 1] = rand_digit();
                  if ($urandom_range(0, 3) == 0)
                     f.push_back(rand_digit());
               end
               1: begin
                  rnd_val = {$urandom, $urandom};
                  if ($urandom_range(0, 1))
                     rnd_val = rnd_val >> $urandom_range(1, 40);
                  push_text(f, $sformatf("%0d", rnd_val));
               end
               2: repeat ($urandom_range(7, 24)) f.push_back(rand_digit());
               default: repeat ($urandom_range(1, 6))
                  f.push_back(rand_digit());
            endcase
            // trailing junk is ignored after the first non-digit
            if ($urandom_range(0, 1))
               repeat ($urandom_range(1, 4)) f.push_back(rand_byte());
         end else if (kind < 70) begin
            repeat ($urandom_range(1, 3))
               f.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
            if ($urandom_range(0, 1))
               repeat ($urandom_range(1, 3)) f.push_back(rand_digit());
         end else if (kind < 88) begin
            repeat ($urandom_range(1, 8)) f.push_back(rand_byte());
         end else begin
            f.push_back($urandom_range(0, 1) ? rand_byte() : rand_digit());
         end
      end
   endtask

   initial begin
      char_q_type  f;
      int unsigned phase_end;
      bit          long_one;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      write_mode(MODE_S32);

      // directed, signed mode
      send_text("+");             // sign without digits
      send_text("+-9");           // both signs, negative
      send_text("-+5");           // plus after minus stops the scan
      f = {8'hFF};                // top character code, alone
      send_field(f);
      f = {8'h00};
      send_field(f);
      send_text("2147483648");    // one past the positive limit, saturates
      send_text("9x");            // junk after a digit

      // random phases, one mode each
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_mode(phase_modes[p]);
         phase_end = items_sent + PHASE_ITEMS;
         long_one  = (p == 1 || p == 3);
         while (items_sent < phase_end) begin
            build_field(long_one, f);
            long_one = 1'b0;
            send_field(f);
         end
      end

      settle();
      if (fail_count == 0)
         $display("PASS decimal_integer_parser");
      else
         $display("FAIL decimal_integer_parser");
      $finish;
   end

endmodule
